// ===== design/rc4_pkg.sv =====
package rc4_pkg;

    // Size of the permutation and width of one byte of it.
    localparam int TABLE_SIZE        = 256;
    localparam int BYTE_W            = 8;

    // Default limit on stored key bytes.
    localparam int MAX_KEY_BYTES_DEF = 256;

    // Request kinds carried in the low bit of the input tuser.
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // One accepted input beat.
    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] byte_in;
        logic              last_key_byte;
        logic              restart_counters;
    } rc4_req_t;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              not_ready;
    } rc4_res_t;

endpackage

// ===== design/rc4_engine.sv =====
module rc4_engine
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  rc4_req_t req,
    output logic     busy,
    input  logic     res_free,
    output logic     res_valid,
    output rc4_res_t res
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KCW    = $clog2(MAX_KEY_BYTES + 1);
    localparam int KCW1   = KCW + 1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_KS_RD = 4'd2;
    localparam logic [3:0] ST_KS_J  = 4'd3;
    localparam logic [3:0] ST_KS_WN = 4'd4;
    localparam logic [3:0] ST_KS_WJ = 4'd5;
    localparam logic [3:0] ST_PG_J  = 4'd6;
    localparam logic [3:0] ST_PG_WI = 4'd7;
    localparam logic [3:0] ST_PG_WJ = 4'd8;
    localparam logic [3:0] ST_PG_RT = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [BYTE_W-1:0] n_reg, n_next;
    logic [KEY_AW-1:0] kidx_reg, kidx_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic              keyed_reg, keyed_next;
    logic [KCW-1:0]    key_count_reg, key_count_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              nrdy_reg, nrdy_next;

    // Memories and their registered read data.
    logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
    logic [BYTE_W-1:0] key_mem  [MAX_KEY_BYTES];
    logic [BYTE_W-1:0] perm_rd_reg;
    logic [BYTE_W-1:0] key_rd_reg;

    logic              perm_we;
    logic [BYTE_W-1:0] perm_waddr;
    logic [BYTE_W-1:0] perm_wdata;
    logic [BYTE_W-1:0] perm_raddr;
    logic              key_we;

    logic [BYTE_W-1:0] i_base, j_base;
    logic [BYTE_W-1:0] t_sum;
    logic [BYTE_W-1:0] ks_j;
    logic [KCW1-1:0]   kidx_inc;
    logic              key_room;

    assign i_base   = req.restart_counters ? '0 : i_reg;
    assign j_base   = req.restart_counters ? '0 : j_reg;
    assign t_sum    = si_reg + sj_reg;
    assign ks_j     = j_reg + perm_rd_reg + key_rd_reg;
    assign kidx_inc = KCW1'(kidx_reg) + 1'b1;
    assign key_room = key_count_reg < KCW'(MAX_KEY_BYTES);

    // Sequencer: key load, schedule and keystream steps through the one table port.
    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        kidx_next      = kidx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        keyed_next     = keyed_reg;
        key_count_next = key_count_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        byte_next      = byte_reg;
        nrdy_next      = nrdy_reg;
        perm_we        = 1'b0;
        perm_waddr     = n_reg;
        perm_wdata     = n_reg;
        perm_raddr     = n_reg;
        key_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                perm_raddr = i_base + 1'b1;
                if (start) begin
                    if (req.req_type == REQ_KEY) begin
                        if (key_room) begin
                            key_we         = 1'b1;
                            key_count_next = key_count_reg + 1'b1;
                        end
                        if (req.last_key_byte) begin
                            n_next     = '0;
                            state_next = ST_FILL;
                        end
                    end else begin
                        byte_next = req.byte_in;
                        j_next    = j_base;
                        if (keyed_reg) begin
                            i_next     = i_base + 1'b1;
                            nrdy_next  = 1'b0;
                            state_next = ST_PG_J;
                        end else begin
                            i_next     = i_base;
                            nrdy_next  = 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                end
            end

            // Identity fill, one entry a cycle.
            ST_FILL: begin
                perm_we = 1'b1;
                n_next  = n_reg + 1'b1;
                if (n_reg == '1) begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_KS_RD;
                end
            end

            // Schedule: read S[n] and the key byte.
            ST_KS_RD: begin
                state_next = ST_KS_J;
            end

            // Schedule: new j, then read S[j].
            ST_KS_J: begin
                si_next    = perm_rd_reg;
                j_next     = ks_j;
                perm_raddr = ks_j;
                state_next = ST_KS_WN;
            end

            ST_KS_WN: begin
                perm_we    = 1'b1;
                perm_wdata = perm_rd_reg;
                state_next = ST_KS_WJ;
            end

            ST_KS_WJ: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                n_next     = n_reg + 1'b1;
                kidx_next  = (kidx_inc == KCW1'(key_count_reg)) ? '0 : kidx_inc[KEY_AW-1:0];
                if (n_reg == '1) begin
                    keyed_next     = 1'b1;
                    key_count_next = '0;
                    i_next         = '0;
                    j_next         = '0;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_KS_RD;
                end
            end

            // Keystream: S[i] is in, update j and read S[j].
            ST_PG_J: begin
                si_next    = perm_rd_reg;
                j_next     = j_reg + perm_rd_reg;
                perm_raddr = j_reg + perm_rd_reg;
                state_next = ST_PG_WI;
            end

            ST_PG_WI: begin
                sj_next    = perm_rd_reg;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rd_reg;
                state_next = ST_PG_WJ;
            end

            ST_PG_WJ: begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                state_next = ST_PG_RT;
            end

            ST_PG_RT: begin
                perm_raddr = t_sum;
                state_next = ST_OUT;
            end

            // Hold the keystream read steady until the result register is free.
            ST_OUT: begin
                perm_raddr = t_sum;
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = state_reg != ST_IDLE;
    assign res_valid     = (state_reg == ST_OUT) && res_free;
    assign res.byte_out  = nrdy_reg ? byte_reg : (byte_reg ^ perm_rd_reg);
    assign res.not_ready = nrdy_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            key_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            key_count_reg <= key_count_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        kidx_reg <= kidx_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        byte_reg <= byte_next;
        nrdy_reg <= nrdy_next;
    end

    // Permutation table: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        perm_rd_reg <= perm_mem[perm_raddr];
    end

    // Key store: written at key beats, read during the schedule.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_count_reg[KEY_AW-1:0]] <= req.byte_in;
        end
        key_rd_reg <= key_mem[kidx_reg];
    end

endmodule

// ===== design/rc4_stream_cipher.sv =====
// RC4 stream cipher on a pair of streaming channels.
// Input beats carry a key byte (tuser bit 0 low) or a data byte (tuser bit 0 high).
// Key beats are stored; one with tlast high runs the key schedule. Data beats are
// XORed with the next keystream byte; tuser bit 1 on a data beat restarts i and j
// at zero first. Each data beat gives one result beat; key beats give none.
// Flow: key beats may follow back to back. A last key beat then runs the schedule:
// an identity fill of the table, then a swap pass that for each entry reads S[n]
// and the key byte, forms j, reads S[j] and writes S[n] and S[j], all on the single
// write port of the permutation table. A data beat takes three reads and two writes
// of the table in turn, then offers its result; the input is ready again once that
// result has moved to the output register. A data beat before any schedule comes
// back unchanged with not_ready set, and the next beat waits until it has moved too.
// s_tready is low while a beat or the schedule is in progress. The result sits in
// an output register; if the receiver stalls, the next data beat is still taken
// and worked on, and waits at its last step until that register is free.
// Reset clears the counters, the stored key length and the keyed flag; the table
// and key store contents are left as they are and are rewritten before use.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // byte_in
    input  logic              s_tlast,   // last_key_byte
    input  logic [1:0]        s_tuser,   // req_type, restart_counters
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // byte_out
    output logic [0:0]        m_tuser    // not_ready
);

    rc4_req_t req;
    rc4_res_t res;
    logic     busy;
    logic     start;
    logic     res_free;
    logic     res_valid;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_nrdy_reg, m_nrdy_next;

    // Unpack the input beat.
    assign req.req_type         = s_tuser[0];
    assign req.byte_in          = s_tdata;
    assign req.last_key_byte    = s_tlast;
    assign req.restart_counters = s_tuser[1];

    assign s_tready = !busy;
    assign start    = s_tvalid && !busy;
    assign res_free = !m_tvalid_reg || m_tready;

    rc4_engine #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: loads a new result when empty or being drained.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_nrdy_next   = m_nrdy_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res.byte_out;
            m_nrdy_next   = res.not_ready;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_nrdy_reg  <= m_nrdy_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_nrdy_reg;

endmodule
